/* hdl/pstm_pkg.sv */
// ----------------------------------------------------------------------------
// pstm_pkg
// Types and constants shared by the poll section tick monitor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pstm_pkg;

  localparam int unsigned CounterBits = 24;
  localparam int unsigned ModeBits    = 3;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned DivSteps    = 32;
  localparam int unsigned DivCntBits  = 5;

  localparam logic [CounterBits-1:0] ReloadReset = '1;

  // Request codes carried in the mode field.
  localparam logic [ModeBits-1:0] ModeEnter     = 3'd0;
  localparam logic [ModeBits-1:0] ModeExpiry    = 3'd1;
  localparam logic [ModeBits-1:0] ModeQuery     = 3'd2;
  localparam logic [ModeBits-1:0] ModeExit      = 3'd3;
  localparam logic [ModeBits-1:0] ModeViolation = 3'd4;
  localparam logic [ModeBits-1:0] ModeSwitch    = 3'd5;

  typedef struct packed {
    logic [ModeBits-1:0]    mode;
    logic                   task_is_poll;
    logic [CounterBits-1:0] counter_sample;
    logic [WordBits-1:0]    cycle_now;
    logic                   cycle_counter_present;
    logic [WordBits-1:0]    budget_in;
  } pstm_in_t;

  typedef struct packed {
    logic                accepted;
    logic                expired;
    logic [WordBits-1:0] elapsed_cycles;
    logic [WordBits-1:0] ticks_to_replay;
    logic                reschedule;
    logic                section_active;
    logic [WordBits-1:0] sections_opened;
    logic [WordBits-1:0] replayed_sum;
    logic [WordBits-1:0] switches_taken;
    logic [WordBits-1:0] budget_overruns;
    logic [WordBits-1:0] block_violations;
    logic [WordBits-1:0] longest_section;
  } pstm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic do_sample;
    logic do_mul;
    logic do_elap;
    logic div_step;
    logic commit;
  } pstm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_last;
  } pstm_stat_t;

endpackage

`default_nettype wire

/* hdl/pstm_div.sv */
// ----------------------------------------------------------------------------
// pstm_div
// Restoring divider: one quotient bit per step, 32 steps per division.
// ----------------------------------------------------------------------------
`default_nettype none

module pstm_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic                                step_i,
  input  wire logic [pstm_pkg::WordBits-1:0]       dividend_i,
  input  wire logic [pstm_pkg::CounterBits:0]      divisor_i,
  output logic      [pstm_pkg::WordBits-1:0]       quotient_o,
  output logic                                     last_o
);
  import pstm_pkg::*;

  localparam int unsigned RemBits = CounterBits + 1;

  logic [WordBits-1:0]   quo_q, quo_d;
  logic [RemBits-1:0]    rem_q, rem_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic [RemBits:0]      rem_shift;
  logic [RemBits+1:0]    trial;
  logic                  ge;

  assign rem_shift = {rem_q, quo_q[WordBits-1]};
  assign trial     = {1'b0, rem_shift} - {2'b00, divisor_i};
  assign ge        = ~trial[RemBits+1];

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
    end else if (step_i) begin
      quo_d = {quo_q[WordBits-2:0], ge};
      rem_d = ge ? trial[RemBits-1:0] : rem_shift[RemBits-1:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quotient_o = quo_q;
  assign last_o     = (cnt_q == DivCntBits'(DivSteps - 1));

endmodule

`default_nettype wire

/* hdl/pstm_datapath.sv */
// ----------------------------------------------------------------------------
// pstm_datapath
// Section state, statistics, elapsed arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pstm_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire pstm_pkg::pstm_cmd_t               cmd_i,
  output pstm_pkg::pstm_stat_t                   stat_o,
  input  wire pstm_pkg::pstm_in_t                in_data_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [pstm_pkg::CounterBits-1:0]  cfg_wdata_i,
  output pstm_pkg::pstm_out_t                    out_data_o
);
  import pstm_pkg::*;

  logic [CounterBits-1:0] reload_q;
  logic [CounterBits:0]   period;

  pstm_in_t  item_q;
  pstm_out_t out_q, res;

  logic                   open_q, open_d;
  logic                   sw_q, sw_d;
  logic [WordBits-1:0]    budget_q, budget_d;
  logic [WordBits-1:0]    start_cyc_q, start_cyc_d;
  logic [CounterBits-1:0] start_ctr_q, start_ctr_d;
  logic [CounterBits-1:0] last_ctr_q, last_ctr_d;
  logic [WordBits-1:0]    wrap_q, wrap_d;
  logic [WordBits-1:0]    sections_q, sections_d;
  logic [WordBits-1:0]    replayed_q, replayed_d;
  logic [WordBits-1:0]    switches_q, switches_d;
  logic [WordBits-1:0]    overruns_q, overruns_d;
  logic [WordBits-1:0]    violations_q, violations_d;
  logic [WordBits-1:0]    longest_q, longest_d;

  logic [WordBits-1:0]             prod_q, elapsed_q;
  logic [WordBits+CounterBits:0]   prod_full;
  logic [WordBits-1:0]             cyc_el, cnt_el, missed, quotient;
  logic                            sample_en, div_last;
  logic                            have_cyc;

  assign period   = {1'b0, reload_q} + 1'b1;
  assign have_cyc = item_q.cycle_counter_present;

  // A counter sample is taken by any expiry check or exit, and by a query
  // without the cycle counter, but only while a section is open.
  assign sample_en = open_q && ((item_q.mode == ModeExpiry) || (item_q.mode == ModeExit) ||
                                ((item_q.mode == ModeQuery) && !have_cyc));

  assign prod_full = wrap_q * period;
  assign cyc_el    = item_q.cycle_now - start_cyc_q;
  assign cnt_el    = prod_q + {{(WordBits-CounterBits){1'b0}}, start_ctr_q}
                            - {{(WordBits-CounterBits){1'b0}}, last_ctr_q};

  pstm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.do_elap),
    .step_i     (cmd_i.div_step),
    .dividend_i (cyc_el),
    .divisor_i  (period),
    .quotient_o (quotient),
    .last_o     (div_last)
  );

  assign stat_o.need_div = open_q && (item_q.mode == ModeExit) && have_cyc;
  assign stat_o.div_last = div_last;

  always_comb begin
    open_d       = open_q;
    sw_d         = sw_q;
    budget_d     = budget_q;
    start_cyc_d  = start_cyc_q;
    start_ctr_d  = start_ctr_q;
    last_ctr_d   = last_ctr_q;
    wrap_d       = wrap_q;
    sections_d   = sections_q;
    replayed_d   = replayed_q;
    switches_d   = switches_q;
    overruns_d   = overruns_q;
    violations_d = violations_q;
    longest_d    = longest_q;
    res          = '0;
    missed       = wrap_q;
    if (have_cyc && (quotient > wrap_q)) begin
      missed = quotient;
    end

    if (cmd_i.do_sample && sample_en) begin
      if (item_q.counter_sample > last_ctr_q) begin
        wrap_d = wrap_q + 1'b1;
      end
      last_ctr_d = item_q.counter_sample;
    end

    if (cmd_i.commit) begin
      case (item_q.mode)
        ModeEnter: begin
          if (item_q.task_is_poll && !open_q) begin
            budget_d     = item_q.budget_in;
            start_cyc_d  = item_q.cycle_now;
            start_ctr_d  = item_q.counter_sample;
            last_ctr_d   = item_q.counter_sample;
            wrap_d       = '0;
            sw_d         = 1'b0;
            open_d       = 1'b1;
            sections_d   = sections_q + 1'b1;
            res.accepted = 1'b1;
          end
        end
        ModeExpiry: begin
          if (!open_q) begin
            res.expired = 1'b1;
          end else if (budget_q != '0) begin
            res.expired = (elapsed_q >= budget_q);
          end
        end
        ModeQuery: begin
          if (open_q) begin
            res.elapsed_cycles = elapsed_q;
          end
        end
        ModeExit: begin
          if (open_q) begin
            res.elapsed_cycles  = elapsed_q;
            res.ticks_to_replay = missed;
            if (elapsed_q > longest_q) begin
              longest_d = elapsed_q;
            end
            if ((budget_q != '0) && (elapsed_q >= budget_q)) begin
              overruns_d = overruns_q + 1'b1;
            end
            open_d     = 1'b0;
            replayed_d = replayed_q + missed;
            if (sw_q) begin
              sw_d           = 1'b0;
              switches_d     = switches_q + 1'b1;
              res.reschedule = 1'b1;
            end else if (missed != '0) begin
              res.reschedule = 1'b1;
            end
          end
        end
        ModeViolation: begin
          if (open_q) begin
            violations_d        = violations_q + 1'b1;
            open_d              = 1'b0;
            replayed_d          = replayed_q + wrap_q;
            res.ticks_to_replay = wrap_q;
          end
        end
        ModeSwitch: begin
          if (open_q) begin
            sw_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    res.section_active   = open_d;
    res.sections_opened  = sections_d;
    res.replayed_sum     = replayed_d;
    res.switches_taken   = switches_d;
    res.budget_overruns  = overruns_d;
    res.block_violations = violations_d;
    res.longest_section  = longest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q     <= ReloadReset;
      open_q       <= 1'b0;
      sw_q         <= 1'b0;
      budget_q     <= '0;
      start_cyc_q  <= '0;
      start_ctr_q  <= '0;
      last_ctr_q   <= '0;
      wrap_q       <= '0;
      sections_q   <= '0;
      replayed_q   <= '0;
      switches_q   <= '0;
      overruns_q   <= '0;
      violations_q <= '0;
      longest_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        reload_q <= cfg_wdata_i;
      end
      open_q       <= open_d;
      sw_q         <= sw_d;
      budget_q     <= budget_d;
      start_cyc_q  <= start_cyc_d;
      start_ctr_q  <= start_ctr_d;
      last_ctr_q   <= last_ctr_d;
      wrap_q       <= wrap_d;
      sections_q   <= sections_d;
      replayed_q   <= replayed_d;
      switches_q   <= switches_d;
      overruns_q   <= overruns_d;
      violations_q <= violations_d;
      longest_q    <= longest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
    if (cmd_i.do_mul) begin
      prod_q <= prod_full[WordBits-1:0];
    end
    if (cmd_i.do_elap) begin
      elapsed_q <= have_cyc ? cyc_el : cnt_el;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* hdl/pstm_ctrl.sv */
// ----------------------------------------------------------------------------
// pstm_ctrl
// Sequencer for one request: sample, multiply, elapsed, divide when needed, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module pstm_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire pstm_pkg::pstm_stat_t stat_i,
  output pstm_pkg::pstm_cmd_t       cmd_o
);
  import pstm_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSample = 3'd1;
  localparam logic [2:0] StMul    = 3'd2;
  localparam logic [2:0] StElap   = 3'd3;
  localparam logic [2:0] StDiv    = 3'd4;
  localparam logic [2:0] StCommit = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register may be reloaded in the same cycle its beat leaves.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = StSample;
        end
      end
      StSample: begin
        cmd_o.do_sample = 1'b1;
        state_d         = StMul;
      end
      StMul: begin
        cmd_o.do_mul = 1'b1;
        state_d      = StElap;
      end
      StElap: begin
        cmd_o.do_elap = 1'b1;
        state_d       = stat_i.need_div ? StDiv : StCommit;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = StCommit;
        end
      end
      StCommit: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hdl/poll_section_tick_monitor_top.sv */
// ----------------------------------------------------------------------------
// poll_section_tick_monitor_top
// Tracks one tick-suppressed poll section and keeps running statistics.
// ----------------------------------------------------------------------------
// Usage: requests arrive as beats on the input channel (in_valid_i/in_ready_o,
// payload in_data_i) and each one gives exactly one result beat on the output
// channel (out_valid_o/out_ready_i, payload out_data_o). The reload register
// is written through cfg_we_i/cfg_wdata_i only while no request is in flight;
// the user must keep to this, as the block does not enforce it. A request
// passes the sample, multiply, elapsed and commit states; an exit on an open
// section with the cycle counter present also passes the divide state, where
// the 32-step restoring divider for elapsed / (reload + 1) runs one quotient
// bit per cycle. One request is in work at a time: the next waits for commit.
// Reset returns the section to closed, zeroes the statistics and sets the
// reload register to all ones. If the receiver stalls, the finished result
// holds in the output register and the next request may still be accepted
// and worked; it then waits before commit until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module poll_section_tick_monitor_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire pstm_pkg::pstm_in_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output pstm_pkg::pstm_out_t                    out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [pstm_pkg::CounterBits-1:0]  cfg_wdata_i
);
  import pstm_pkg::*;

  pstm_cmd_t  cmd;
  pstm_stat_t stat;

  pstm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pstm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
